// ===== hdl/kmlc_pkg.sv =====
// Shared constants, types and helpers for the k-means Lab cluster pass.
`timescale 1ns / 1ps
`default_nettype none
package kmlc_pkg;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 20;
  localparam int L_W    = 15;
  localparam int AB_W   = 16;
  localparam int DIST_W = 34;
  localparam int DIFF_W = 17;
  localparam int K_CFG_W = 5;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  // Input item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_K   = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_EPS = 4'd8;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Per-cell control strobes
  typedef struct packed {
    logic ld;   // write a new centre
    logic clr;  // clear sums and count
    logic acc;  // add the held point
  } cell_ctrl_t;

  // Square of a 17-bit signed difference
  function automatic logic [DIST_W-1:0] sq17(input logic signed [DIFF_W-1:0] x);
    logic signed [2*DIFF_W-1:0] p;
    p = x * x;
    return p[DIST_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/kmlc_cell.sv =====
// One centre cell: holds a centre, its sums and count, and forwards the nearest-centre token.
`timescale 1ns / 1ps
`default_nettype none
module kmlc_cell #(
  parameter int IDX = 0,
  parameter int IW = 4,
  parameter int COUNT_BITS = 20,
  parameter int SW = 37
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic active,
  input  wire kmlc_pkg::cell_ctrl_t ctl,
  input  wire logic [kmlc_pkg::L_W-1:0]  pt_l,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] pt_a,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] pt_b,
  input  wire logic [kmlc_pkg::L_W-1:0]  wr_l,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] wr_a,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] wr_b,
  input  wire logic tok_in_v,
  input  wire logic [kmlc_pkg::DIST_W-1:0] tok_in_d,
  input  wire logic [IW-1:0] tok_in_i,
  output logic tok_out_v,
  output logic [kmlc_pkg::DIST_W-1:0] tok_out_d,
  output logic [IW-1:0] tok_out_i,
  output logic [kmlc_pkg::L_W-1:0] c_l,
  output logic signed [kmlc_pkg::AB_W-1:0] c_a,
  output logic signed [kmlc_pkg::AB_W-1:0] c_b,
  output logic signed [SW-1:0] s_l,
  output logic signed [SW-1:0] s_a,
  output logic signed [SW-1:0] s_b,
  output logic [COUNT_BITS-1:0] cnt
);
  logic [kmlc_pkg::L_W-1:0] c_l_r;
  logic signed [kmlc_pkg::AB_W-1:0] c_a_r, c_b_r;
  logic signed [SW-1:0] s_l_r, s_a_r, s_b_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic tok_v_r;
  logic [kmlc_pkg::DIST_W-1:0] tok_d_r, d_own;
  logic [IW-1:0] tok_i_r;
  logic signed [kmlc_pkg::DIFF_W-1:0] dl, da, db;
  logic take;

  // Distance from the held point to this centre
  always_comb begin
    dl = $signed({2'b00, pt_l}) - $signed({2'b00, c_l_r});
    da = $signed({pt_a[kmlc_pkg::AB_W-1], pt_a}) - $signed({c_a_r[kmlc_pkg::AB_W-1], c_a_r});
    db = $signed({pt_b[kmlc_pkg::AB_W-1], pt_b}) - $signed({c_b_r[kmlc_pkg::AB_W-1], c_b_r});
    d_own = kmlc_pkg::sq17(dl) + kmlc_pkg::sq17(da) + kmlc_pkg::sq17(db);
    // strict less keeps the lower index on ties; cell zero always takes the token
    take = active && ((IDX == 0) || (d_own < tok_in_d));
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_in_v;
    end
    tok_d_r <= take ? d_own : tok_in_d;
    tok_i_r <= take ? IW'(IDX) : tok_in_i;
  end

  // Centre and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_l_r <= '0;
      c_a_r <= '0;
      c_b_r <= '0;
      s_l_r <= '0;
      s_a_r <= '0;
      s_b_r <= '0;
      cnt_r <= '0;
    end else begin
      if (ctl.ld) begin
        c_l_r <= wr_l;
        c_a_r <= wr_a;
        c_b_r <= wr_b;
      end
      if (ctl.clr) begin
        s_l_r <= '0;
        s_a_r <= '0;
        s_b_r <= '0;
        cnt_r <= '0;
      end else if (ctl.acc && (cnt_r != {COUNT_BITS{1'b1}})) begin
        cnt_r <= cnt_r + 1'b1;
        s_l_r <= s_l_r + $signed({{(SW-kmlc_pkg::L_W){1'b0}}, pt_l});
        s_a_r <= s_a_r + SW'(pt_a);
        s_b_r <= s_b_r + SW'(pt_b);
      end
    end
  end

  assign tok_out_v = tok_v_r;
  assign tok_out_d = tok_d_r;
  assign tok_out_i = tok_i_r;
  assign c_l = c_l_r;
  assign c_a = c_a_r;
  assign c_b = c_b_r;
  assign s_l = s_l_r;
  assign s_a = s_a_r;
  assign s_b = s_b_r;
  assign cnt = cnt_r;
endmodule
`default_nettype wire

// ===== hdl/kmlc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kmlc_div #(
  parameter int NW = 37,
  parameter int DW = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0] rem_r, trial, diff;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic run_r, done_r, ge;

  always_comb begin
    trial = {rem_r[DW-1:0], quo_r[NW-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses in the cycle after the last quotient bit
      done_r <= !start && run_r && (cnt_r == CW'(NW - 1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= ge ? diff : trial;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== hdl/kmeans_lab_cluster_pass.sv =====
// Top level of the k-means Lab cluster pass: command port, cell chain and report sequencer.
// Usage:
//  - Items enter on start while busy is low. mode 0 loads a centre (slot, L, a, b) and
//    gives no result; mode 3 is ignored.
//  - mode 1 clusters a point: the point is held, then a token walks the chain of MAX_CLUSTERS
//    centre cells, one cell per cycle, keeping the nearest centre (lowest index on ties). The
//    assignment appears on out_valid, and the winning cell adds the point to its sums and count
//    in that same cycle. A new point is taken only once busy falls with the assignment.
//  - mode 2 ends the pass: each cluster in use is reported in order. A non-empty cluster
//    runs three divisions of its sums by its count on a shared bit-serial divider of width
//    SW = COUNT_BITS+17, then the shift check and the report. The last report carries last
//    and converged.
//  - Results show on out_valid for one cycle each; the receiver cannot stall.
//  - Registers: clusters_used at byte 0, eps_squared at byte 8, 64-bit APB data.
//  - Synchronous reset clears all centres, sums and counts and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_lab_cluster_pass #(
  parameter int MAX_CLUSTERS = kmlc_pkg::MAX_CLUSTERS_DEF,
  parameter int COUNT_BITS   = kmlc_pkg::COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_mode,
  input  wire logic [3:0] in_slot,
  input  wire logic [kmlc_pkg::L_W-1:0] in_l_value,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] in_a_value,
  input  wire logic signed [kmlc_pkg::AB_W-1:0] in_b_value,
  output logic out_valid,
  output logic out_kind,
  output logic [3:0] out_cluster_index,
  output logic [kmlc_pkg::DIST_W-1:0] out_dist_sq,
  output logic [kmlc_pkg::L_W-1:0] out_center_l,
  output logic signed [kmlc_pkg::AB_W-1:0] out_center_a,
  output logic signed [kmlc_pkg::AB_W-1:0] out_center_b,
  output logic [COUNT_BITS-1:0] out_member_count,
  output logic out_is_empty,
  output logic out_moved,
  output logic out_converged,
  output logic out_last,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [kmlc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [kmlc_pkg::DATA_W-1:0] pwdata,
  output logic [kmlc_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  localparam int IW = $clog2(MAX_CLUSTERS);
  localparam int KW = $clog2(MAX_CLUSTERS + 1);
  localparam int SW = COUNT_BITS + 17;
  localparam int LW = kmlc_pkg::L_W;
  localparam int AW = kmlc_pkg::AB_W;
  localparam int DW = kmlc_pkg::DIST_W;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_SQ, ST_REP} state_t;

  // Configuration registers
  logic [kmlc_pkg::K_CFG_W-1:0] k_cfg_r;
  logic [DW-1:0] eps_r;
  logic cfg_wr;
  logic [KW-1:0] k_use;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r <= kmlc_pkg::K_CFG_W'(16);
      eps_r   <= DW'(65536);
    end else if (cfg_wr) begin
      case (paddr)
        kmlc_pkg::ADDR_K:   k_cfg_r <= pwdata[kmlc_pkg::K_CFG_W-1:0];
        kmlc_pkg::ADDR_EPS: eps_r   <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      kmlc_pkg::ADDR_K:   prdata = kmlc_pkg::DATA_W'(k_cfg_r);
      kmlc_pkg::ADDR_EPS: prdata = kmlc_pkg::DATA_W'(eps_r);
      default:            prdata = '0;
    endcase
    if (k_cfg_r == '0) k_use = KW'(1);
    else if (int'(k_cfg_r) > MAX_CLUSTERS) k_use = KW'(MAX_CLUSTERS);
    else k_use = KW'(k_cfg_r);
  end

  // Sequencer state
  state_t st_r;
  logic [LW-1:0] pt_l_r;
  logic signed [AW-1:0] pt_a_r, pt_b_r;
  logic [IW-1:0] rep_r;
  logic [1:0] ch_r;
  logic run_r, conv_r, launch_r;
  logic [LW-1:0] nl_r;
  logic signed [AW-1:0] na_r, nb_r;
  logic [DW-1:0] sql_r, sqa_r, sqb_r;

  // Chain wiring
  kmlc_pkg::cell_ctrl_t ctl [MAX_CLUSTERS];
  logic tv [MAX_CLUSTERS+1];
  logic [DW-1:0] td [MAX_CLUSTERS+1];
  logic [IW-1:0] ti [MAX_CLUSTERS+1];
  logic [LW-1:0] cl [MAX_CLUSTERS];
  logic signed [AW-1:0] ca [MAX_CLUSTERS], cb [MAX_CLUSTERS];
  logic signed [SW-1:0] sl [MAX_CLUSTERS], sa [MAX_CLUSTERS], sb [MAX_CLUSTERS];
  logic [COUNT_BITS-1:0] cn [MAX_CLUSTERS];
  logic [LW-1:0] wr_l;
  logic signed [AW-1:0] wr_a, wr_b;
  logic accept;

  // token enters the chain once the point sits in the hold registers
  assign accept = start && (st_r == ST_IDLE);
  assign busy   = (st_r != ST_IDLE);
  assign tv[0]  = launch_r;
  assign td[0]  = {DW{1'b1}};
  assign ti[0]  = '0;

  // Centre write data: a load takes the input item, a report its new mean (its old centre when empty)
  always_comb begin
    if (st_r == ST_REP) begin
      wr_l = nl_r;
      wr_a = na_r;
      wr_b = nb_r;
    end else begin
      wr_l = in_l_value;
      wr_a = in_a_value;
      wr_b = in_b_value;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
      always_comb begin
        ctl[g].ld  = (accept && (in_mode == kmlc_pkg::MODE_LOAD)
                      && (32'(in_slot) == g))
                     || ((st_r == ST_REP) && (rep_r == IW'(g)));
        ctl[g].clr = (st_r == ST_REP) && (rep_r == IW'(g));
        ctl[g].acc = (st_r == ST_SCAN) && tv[MAX_CLUSTERS] && (ti[MAX_CLUSTERS] == IW'(g));
      end
      kmlc_cell #(.IDX(g), .IW(IW), .COUNT_BITS(COUNT_BITS), .SW(SW)) u_cell (
        .clk(clk), .rst_n(rst_n), .active(g < int'(k_use)), .ctl(ctl[g]),
        .pt_l(pt_l_r), .pt_a(pt_a_r), .pt_b(pt_b_r),
        .wr_l(wr_l), .wr_a(wr_a), .wr_b(wr_b),
        .tok_in_v(tv[g]), .tok_in_d(td[g]), .tok_in_i(ti[g]),
        .tok_out_v(tv[g+1]), .tok_out_d(td[g+1]), .tok_out_i(ti[g+1]),
        .c_l(cl[g]), .c_a(ca[g]), .c_b(cb[g]),
        .s_l(sl[g]), .s_a(sa[g]), .s_b(sb[g]), .cnt(cn[g])
      );
    end
  endgenerate

  // Selected cluster for the report
  logic [COUNT_BITS-1:0] c_sel;
  logic signed [SW-1:0] s_sel;
  logic [SW-1:0] mag;
  logic neg, dv_start, dv_done;
  logic [SW-1:0] quo, q_signed;
  logic empty, moved, is_last, conv_nxt;
  logic [DW:0] total;

  always_comb begin
    c_sel = cn[rep_r];
    case (ch_r)
      2'd0:    s_sel = sl[rep_r];
      2'd1:    s_sel = sa[rep_r];
      default: s_sel = sb[rep_r];
    endcase
    neg      = s_sel[SW-1];
    mag      = neg ? SW'(-s_sel) : SW'(s_sel);
    q_signed = neg ? SW'(-quo) : quo;
    dv_start = (st_r == ST_DIV) && !run_r && (c_sel != '0);
    empty    = (c_sel == '0);
    total    = {1'b0, sql_r} + {1'b0, sqa_r} + {1'b0, sqb_r};
    moved    = !empty && (total > {1'b0, eps_r});
    is_last  = (KW'(rep_r) == k_use - KW'(1));
    conv_nxt = conv_r && !empty && !moved;
  end

  kmlc_div #(.NW(SW), .DW(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(mag), .den(c_sel),
    .done(dv_done), .quo(quo)
  );

  // Output registers
  logic ov_r, ok_r, oe_r, om_r, oc_r, olast_r;
  logic [3:0] oi_r;
  logic [DW-1:0] od_r;
  logic [LW-1:0] ol_r;
  logic signed [AW-1:0] oa_r, ob_r;
  logic [COUNT_BITS-1:0] on_r;

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      ov_r     <= 1'b0;
      run_r    <= 1'b0;
      conv_r   <= 1'b1;
      rep_r    <= '0;
      ch_r     <= '0;
      launch_r <= 1'b0;
    end else begin
      ov_r     <= ((st_r == ST_SCAN) && tv[MAX_CLUSTERS]) || (st_r == ST_REP);
      launch_r <= accept && (in_mode == kmlc_pkg::MODE_POINT);
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            pt_l_r <= in_l_value;
            pt_a_r <= in_a_value;
            pt_b_r <= in_b_value;
            rep_r  <= '0;
            ch_r   <= '0;
            run_r  <= 1'b0;
            conv_r <= 1'b1;
            if (in_mode == kmlc_pkg::MODE_POINT) st_r <= ST_SCAN;
            else if (in_mode == kmlc_pkg::MODE_END) st_r <= ST_DIV;
          end
        end
        ST_SCAN: begin
          if (tv[MAX_CLUSTERS]) begin
            ok_r    <= kmlc_pkg::KIND_ASSIGN;
            oi_r    <= 4'(ti[MAX_CLUSTERS]);
            od_r    <= td[MAX_CLUSTERS];
            ol_r    <= '0;
            oa_r    <= '0;
            ob_r    <= '0;
            on_r    <= '0;
            oe_r    <= 1'b0;
            om_r    <= 1'b0;
            oc_r    <= 1'b0;
            olast_r <= 1'b1;
            st_r    <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (empty) begin
            nl_r <= cl[rep_r];
            na_r <= ca[rep_r];
            nb_r <= cb[rep_r];
            st_r <= ST_SQ;
          end else if (!run_r) begin
            run_r <= 1'b1;
          end else if (dv_done) begin
            run_r <= 1'b0;
            case (ch_r)
              2'd0:    nl_r <= q_signed[LW-1:0];
              2'd1:    na_r <= q_signed[AW-1:0];
              default: nb_r <= q_signed[AW-1:0];
            endcase
            if (ch_r == 2'd2) st_r <= ST_SQ;
            else ch_r <= ch_r + 1'b1;
          end
        end
        ST_SQ: begin
          sql_r <= kmlc_pkg::sq17($signed({2'b00, nl_r}) - $signed({2'b00, cl[rep_r]}));
          sqa_r <= kmlc_pkg::sq17($signed({na_r[AW-1], na_r})
                                  - $signed({ca[rep_r][AW-1], ca[rep_r]}));
          sqb_r <= kmlc_pkg::sq17($signed({nb_r[AW-1], nb_r})
                                  - $signed({cb[rep_r][AW-1], cb[rep_r]}));
          st_r  <= ST_REP;
        end
        ST_REP: begin
          ok_r    <= kmlc_pkg::KIND_REPORT;
          oi_r    <= 4'(rep_r);
          od_r    <= '0;
          ol_r    <= nl_r;
          oa_r    <= na_r;
          ob_r    <= nb_r;
          on_r    <= c_sel;
          oe_r    <= empty;
          om_r    <= moved;
          oc_r    <= is_last && conv_nxt;
          olast_r <= is_last;
          conv_r  <= conv_nxt;
          ch_r    <= '0;
          if (is_last) begin
            st_r <= ST_IDLE;
          end else begin
            rep_r <= rep_r + 1'b1;
            st_r  <= ST_DIV;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_cluster_index = oi_r;
  assign out_dist_sq       = od_r;
  assign out_center_l      = ol_r;
  assign out_center_a      = oa_r;
  assign out_center_b      = ob_r;
  assign out_member_count  = on_r;
  assign out_is_empty      = oe_r;
  assign out_moved         = om_r;
  assign out_converged     = oc_r;
  assign out_last          = olast_r;
endmodule
`default_nettype wire
